>>> design/sssg_pkg.sv
// ----------------------------------------------------------------------------
// sssg_pkg
// Shared constants for the sorted-set span-minus-gap unit: default sizes and
// result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sssg_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned COORD_BITS_DEF = 30;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

endpackage

`default_nettype wire

>>> design/sssg_store.sv
// ----------------------------------------------------------------------------
// sssg_store
// Member store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sssg_store #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 30,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/sssg_alu.sv
// ----------------------------------------------------------------------------
// sssg_alu
// Shared subtract and compare unit used by the search, gap scan and span step.
// ----------------------------------------------------------------------------
`default_nettype none

module sssg_alu #(
  parameter int unsigned WIDTH = 30
) (
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic      [WIDTH-1:0] diff,
  output logic                  ge,
  output logic                  eq
);

  // Difference and ordering from one subtractor, equality from a comparator
  logic [WIDTH:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[WIDTH-1:0];
  assign ge   = ~wide[WIDTH];
  assign eq   = (a == b);

endmodule

`default_nettype wire

>>> design/sorted_set_span_minus_max_gap_unit.sv
// Sequence: the search stops one entry past the match, the shift moves only
// the entries above it, the gap scan reads every member, one entry per cycle.
// Throughput: one request at a time; in_stall is high until the result is
// loaded into the output register, which then waits on out_stall.
// Reset: synchronous, clears the member count, set size, state and valid flags.
`default_nettype none

module sorted_set_span_minus_max_gap_unit
  import sssg_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned CNT_W      = $clog2(CAPACITY + 1),
  parameter int unsigned ADDR_W     = $clog2(CAPACITY)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  action,
  input  wire logic [COORD_BITS-1:0] coord,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [COORD_BITS-1:0] answer,
  output logic      [1:0]            status,
  output logic      [CNT_W-1:0]      member_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_GAP    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]            state;
  logic [CNT_W-1:0]      total;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      pos;
  logic [CNT_W-1:0]      ridx;
  logic                  rv;
  logic                  found;
  logic                  present;
  logic                  ins;
  logic [COORD_BITS-1:0] val;
  logic [1:0]            res_status;
  logic [COORD_BITS-1:0] prev;
  logic [COORD_BITS-1:0] first;
  logic [COORD_BITS-1:0] maxg;
  logic [COORD_BITS-1:0] span;

  logic                  issue;
  logic [CNT_W-1:0]      raddr_full;
  logic [CNT_W-1:0]      waddr_full;
  logic                  we;
  logic [COORD_BITS-1:0] wdata;
  logic [COORD_BITS-1:0] rdata;
  logic [COORD_BITS-1:0] alu_a;
  logic [COORD_BITS-1:0] alu_b;
  logic [COORD_BITS-1:0] alu_diff;
  logic                  alu_ge;
  logic                  alu_eq;

  // Read issue and address for the streaming passes
  always_comb begin
    issue      = 1'b0;
    raddr_full = idx;
    unique case (state)
      S_FIND:  issue = !found && (idx < total);
      S_GAP:   issue = (idx < total);
      S_SHIFT: begin
        if (ins) begin
          issue      = (idx > pos);
          raddr_full = idx - CNT_W'(1);
        end else begin
          issue      = (idx < total);
        end
      end
      default: issue = 1'b0;
    endcase
  end

  // Store writes: moved entries during the shift, new member on placement
  always_comb begin
    we         = 1'b0;
    waddr_full = pos;
    wdata      = rdata;
    if (state == S_SHIFT && rv) begin
      we         = 1'b1;
      waddr_full = ins ? (ridx + CNT_W'(1)) : (ridx - CNT_W'(1));
    end else if (state == S_PLACE) begin
      we    = 1'b1;
      wdata = val;
    end
  end

  // Shared unit operands
  always_comb begin
    alu_a = rdata;
    alu_b = val;
    if (state == S_GAP) begin
      alu_b = prev;
    end else if (state == S_FIN) begin
      alu_a = prev;
      alu_b = first;
    end
  end

  sssg_store #(
    .DEPTH (CAPACITY),
    .WIDTH (COORD_BITS),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr_full[ADDR_W-1:0]),
    .wdata(wdata),
    .raddr(raddr_full[ADDR_W-1:0]),
    .rdata(rdata)
  );

  sssg_alu #(
    .WIDTH(COORD_BITS)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .diff(alu_diff),
    .ge  (alu_ge),
    .eq  (alu_eq)
  );

  assign in_stall = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total        <= '0;
      rv           <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
      member_count <= '0;
    end else begin
      rv   <= issue;
      ridx <= raddr_full;
      if (issue) begin
        if (state == S_SHIFT && ins) begin
          idx <= idx - CNT_W'(1);
        end else begin
          idx <= idx + CNT_W'(1);
        end
      end

      // Raise valid when a result is loaded, drop it once taken
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ins     <= action;
            val     <= coord;
            idx     <= '0;
            pos     <= total;
            found   <= 1'b0;
            present <= 1'b0;
            state   <= S_FIND;
          end
        end
        S_FIND: begin
          // Hold the first entry not below the request value
          if (rv && !found && alu_ge) begin
            found   <= 1'b1;
            pos     <= ridx;
            present <= alu_eq;
          end
          if (!issue && !rv) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (ins && present) begin
            res_status <= ST_IGNORED;
            state      <= S_GAP;
          end else if (ins && total == CNT_W'(CAPACITY)) begin
            res_status <= ST_FULL;
            state      <= S_GAP;
          end else if (!ins && !present) begin
            res_status <= ST_IGNORED;
            state      <= S_GAP;
          end else begin
            res_status <= ST_DONE;
            idx        <= ins ? total : (pos + CNT_W'(1));
            state      <= S_SHIFT;
          end
          if (!(ins && !present && total != CNT_W'(CAPACITY)) && !(!ins && present)) begin
            idx <= '0;
          end
        end
        S_SHIFT: begin
          if (!issue && !rv) begin
            if (ins) begin
              state <= S_PLACE;
            end else begin
              total <= total - CNT_W'(1);
              idx   <= '0;
              state <= S_GAP;
            end
          end
        end
        S_PLACE: begin
          total <= total + CNT_W'(1);
          idx   <= '0;
          state <= S_GAP;
        end
        S_GAP: begin
          // Track first member, previous member and widest gap
          if (rv) begin
            prev <= rdata;
            if (ridx == '0) begin
              first <= rdata;
              maxg  <= '0;
            end else if (alu_diff > maxg) begin
              maxg <= alu_diff;
            end
          end
          if (!issue && !rv) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          span  <= alu_diff;
          state <= S_DONE;
        end
        S_DONE: begin
          // Load the result once the output register is free
          if (!out_valid || !out_stall) begin
            answer       <= (total < CNT_W'(2)) ? '0 : (span - maxg);
            status       <= res_status;
            member_count <= total;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/sssg_checker.sv
// ----------------------------------------------------------------------------
// sssg_checker
// Port-level checks on the span-minus-gap unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sssg_checker
  import sssg_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [COORD_BITS-1:0] answer,
  input wire logic [1:0]            status,
  input wire logic [CNT_W-1:0]      member_count
);

  // A request keeps the unit busy on the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("unit took a request back to back");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(answer) && $stable(status)
      && $stable(member_count))
    else $error("stalled result changed");

  // Status code is one of the defined ones
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DONE || status == ST_IGNORED || status == ST_FULL))
    else $error("undefined status code");

  // Member count never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    member_count <= CNT_W'(CAPACITY))
    else $error("member count above capacity");

  // Fewer than two members gives a zero answer
  a_small: assert property (@(posedge clk) disable iff (rst)
    out_valid && member_count < CNT_W'(2) |-> answer == '0)
    else $error("non-zero answer for small set");

endmodule

bind sorted_set_span_minus_max_gap_unit sssg_checker #(
  .CAPACITY  (CAPACITY),
  .COORD_BITS(COORD_BITS),
  .CNT_W     (CNT_W)
) u_sssg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .answer      (answer),
  .status      (status),
  .member_count(member_count)
);

`default_nettype wire

>>> tb/sv/sorted_set_span_minus_max_gap_unit_test.sv
// ----------------------------------------------------------------------------
// Sorted-set span-minus-gap unit test
// Drives insert and remove requests with bursty timing and a stalling
// receiver, predicts every result from a local sorted set, and checks answer,
// status and member count in order. Directed rows come first, then random
// sequences that grow the set and thin it out again.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module sorted_set_span_minus_max_gap_unit_test;
  import sssg_pkg::*;

  localparam int unsigned CAP   = CAPACITY_DEF;
  localparam int unsigned CBITS = COORD_BITS_DEF;
  localparam int unsigned CNTW  = $clog2(CAP + 1);
  localparam logic [CBITS-1:0] CMAX = {CBITS{1'b1}};
  localparam logic ACT_REMOVE = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic [CBITS-1:0] answer;
    logic [1:0]       status;
    logic [CNTW-1:0]  count;
  } set_result_t;

  typedef struct {
    logic             act;
    logic [CBITS-1:0] coord;
    logic             typed;
    set_result_t      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [CBITS-1:0] coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CBITS-1:0] answer;
  logic [1:0] status;
  logic [CNTW-1:0] member_count;

  // local copy of the set, ascending
  logic [CBITS-1:0] set_members[$];
  set_result_t pending_results[$];
  int errors = 0;
  bit stim_done = 1'b0;

  sorted_set_span_minus_max_gap_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .action, .coord,
    .out_valid, .out_stall, .answer, .status, .member_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one request to the local set and return the result it should give
  function automatic set_result_t apply_request(input logic act, input logic [CBITS-1:0] v);
    set_result_t r;
    int pos;
    bit present;
    logic [CBITS-1:0] widest;
    logic [CBITS-1:0] g;
    pos = 0;
    while (pos < set_members.size() && set_members[pos] < v) pos++;
    present = pos < set_members.size() && set_members[pos] == v;
    r.status = ST_DONE;
    if (act == ACT_INSERT) begin
      if (present) r.status = ST_IGNORED;
      else if (set_members.size() >= CAP) r.status = ST_FULL;
      else set_members.insert(pos, v);
    end else begin
      if (!present) r.status = ST_IGNORED;
      else set_members.delete(pos);
    end
    r.answer = '0;
    if (set_members.size() >= 2) begin
      widest = '0;
      for (int i = 1; i < set_members.size(); i++) begin
        g = set_members[i] - set_members[i-1];
        if (g > widest) widest = g;
      end
      r.answer = set_members[$] - set_members[0] - widest;
    end
    r.count = CNTW'(set_members.size());
    return r;
  endfunction

  // hand one request to the block and hold it until taken
  task automatic send_request(input logic act, input logic [CBITS-1:0] v);
    in_valid <= 1'b1;
    action   <= act;
    coord    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_request(act, v));
  endtask

  // idle the sender for a random gap, or not at all
  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // random coordinate, biased to small values and extremes
  function automatic logic [CBITS-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CBITS'($urandom_range(0, 15));
      2: return CMAX - CBITS'($urandom_range(0, 15));
      default: return CBITS'($urandom());
    endcase
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else case ($urandom_range(0, 9))
      0, 1, 2: out_stall <= 1'b1;
      default: out_stall <= 1'b0;
    endcase
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result answer=%0d status=%0d count=%0d", answer, status,
               member_count);
        errors++;
      end else begin
        set_result_t e;
        e = pending_results.pop_front();
        if (answer !== e.answer) begin
          $error("answer: expected %0d, got %0d", e.answer, answer);
          errors++;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
        if (member_count !== e.count) begin
          $error("member_count: expected %0d, got %0d", e.count, member_count);
          errors++;
        end
      end
    end
  end

  stim_row_t directed_rows[] = '{
    '{ACT_REMOVE, 30'd5,    1'b1, '{30'd0, ST_IGNORED, 11'd0}},
    '{ACT_INSERT, 30'd0,    1'b1, '{30'd0, ST_DONE,    11'd1}},
    '{ACT_INSERT, 30'd0,    1'b1, '{30'd0, ST_IGNORED, 11'd1}},
    '{ACT_INSERT, CMAX,     1'b1, '{30'd0, ST_DONE,    11'd2}},
    '{ACT_INSERT, 30'd10,   1'b0, '{30'd0, ST_DONE,    11'd0}},
    '{ACT_INSERT, 30'd20,   1'b0, '{30'd0, ST_DONE,    11'd0}},
    '{ACT_REMOVE, 30'd7,    1'b1, '{30'd20, ST_IGNORED, 11'd4}},
    '{ACT_REMOVE, CMAX,     1'b1, '{30'd10, ST_DONE,   11'd3}},
    '{ACT_INSERT, 30'h2AAAAAAA, 1'b0, '{30'd0, ST_DONE, 11'd0}},
    '{ACT_INSERT, 30'h15555555, 1'b0, '{30'd0, ST_DONE, 11'd0}},
    '{ACT_REMOVE, 30'd0,    1'b0, '{30'd0, ST_DONE,    11'd0}},
    '{ACT_REMOVE, 30'd10,   1'b0, '{30'd0, ST_DONE,    11'd0}},
    '{ACT_REMOVE, 30'd20,   1'b0, '{30'd0, ST_DONE,    11'd0}},
    '{ACT_REMOVE, 30'h2AAAAAAA, 1'b0, '{30'd0, ST_DONE, 11'd0}},
    '{ACT_REMOVE, 30'h15555555, 1'b1, '{30'd0, ST_DONE, 11'd0}},
    '{ACT_REMOVE, 30'h15555555, 1'b1, '{30'd0, ST_IGNORED, 11'd0}}
  };

  // stimulus
  initial begin
    set_result_t predicted;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; typed results replace the prediction
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].act, directed_rows[i].coord);
      if (directed_rows[i].typed) begin
        predicted = pending_results.pop_back();
        pending_results.push_back(directed_rows[i].res);
        if (predicted != directed_rows[i].res) begin
          $error("row %0d: typed result disagrees with prediction", i);
          errors++;
        end
      end
      sender_gap();
    end

    // hold off until the block has drained
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // random mix on a small set
    for (int n = 0; n < 120; n++) begin
      if (set_members.size() > 0 && $urandom_range(0, 2) == 0)
        send_request(ACT_REMOVE, set_members[$urandom_range(0, set_members.size() - 1)]);
      else if ($urandom_range(0, 4) == 0 && set_members.size() > 0)
        send_request(ACT_INSERT, set_members[$urandom_range(0, set_members.size() - 1)]);
      else
        send_request(1'($urandom_range(0, 1)), pick_coord());
      sender_gap();
    end

    // grow the set, retry a present value, then take a few back out
    for (int n = 0; n < 110; n++) begin
      send_request(ACT_INSERT, CBITS'($urandom()));
      if (n % 16 == 0) sender_gap();
    end
    send_request(ACT_INSERT, set_members[0]);
    send_request(ACT_INSERT, CMAX - CBITS'(1));
    send_request(ACT_INSERT, CBITS'($urandom()));
    for (int n = 0; n < 40; n++) begin
      if ($urandom_range(0, 1) == 0)
        send_request(ACT_REMOVE, set_members[$urandom_range(0, set_members.size() - 1)]);
      else
        send_request(ACT_INSERT, pick_coord());
      sender_gap();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // wait for the last result, let the block settle, then report
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * CAP + 20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #200_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
